// ----- rtl/bb3s_pkg.sv -----
// types and constants shared by the 3x3 box blur stream block
// no dependencies; imported by every module of the block
`default_nettype none

package bb3s_pkg;

    // configuration register indexes
    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    // input operation codes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_WIDTH_W  = 12;
    localparam int CFG_HEIGHT_W = 13;

    localparam int PIX_W = 8;
    // sum of nine 8-bit pixels is at most 2295
    localparam int SUM_W = 12;

    // divide by 9 as multiply by ceil(2^16 / 9) and shift; exact for sums below 32768
    localparam int                  RECIP_W     = 13;
    localparam logic [RECIP_W-1:0]  RECIP_9     = 13'd7282;
    localparam int                  RECIP_SHIFT = 16;
    localparam int                  PROD_W      = SUM_W + RECIP_W;

    // input item: op selects pixel or flush tick
    typedef struct packed {
        logic             op;
        logic [PIX_W-1:0] pixel_in;
    } bb3s_in_t;

    // result item
    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             frame_last;
    } bb3s_out_t;

    // per-item flags carried down the pipeline
    typedef struct packed {
        logic border;
        logic last;
    } bb3s_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/box_blur_3x3_stream.sv -----
// 3x3 box blur over a raster pixel stream
// top level; depends on bb3s_pkg, bb3s_line_buf, bb3s_window, bb3s_div9
//
// usage: pixels enter on the s_ channel (valid/ready) in raster order, op = 0.
// results leave on the m_ channel in raster order: interior pixels carry the
// truncated 3x3 mean, first/last rows and columns pass through. results lag
// input by one row plus one pixel; after the last pixel send image_width + 1
// flush transfers (op = 1) to drain the frame, the final result has frame_last.
// a flush sent before the frame is complete is taken and dropped.
// throughput: one transfer per clock while m_ready stays high; the line memories
// are read at accept and written back as the item leaves stage b, with a bypass
// for back-to-back hits. a result passes stage b, stage c and the output register.
// the pipeline stages collapse bubbles, so input keeps flowing while a result
// waits in the output register; when all stages fill, s_ready drops until m_ready.
// reset (aresetn, synchronous, active low) empties the pipeline, clears the
// position counters and window, and loads width 1192, height 500. line memory
// contents are not cleared; unwritten entries only feed border results.
// configuration: cfg_wen with cfg_index/cfg_wdata, only while idle.
`default_nettype none

module box_blur_3x3_stream
    import bb3s_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_wen,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire bb3s_in_t               s_data,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output bb3s_out_t                   m_data
);

    localparam int IW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT + 2);

    logic [CFG_WIDTH_W-1:0]  width_reg;
    logic [CFG_HEIGHT_W-1:0] height_reg;
    logic [IW-1:0]           col_reg, col_next;
    logic [RW-1:0]           row_reg, row_next;

    logic [31:0] w_ext, h_ext, col_ext, row_ext, col_inc;
    logic        accept, ignore, proc;
    logic        emit_a;
    bb3s_ctl_t   ctl_a;
    logic [PIX_W-1:0] pixel_a;

    logic             valid_b_reg, emit_b_reg;
    logic [PIX_W-1:0] pixel_b_reg;
    logic [IW-1:0]    addr_b_reg;
    bb3s_ctl_t        ctl_b_reg;
    logic             valid_c_reg, valid_d_reg;
    logic             en_b, en_c, en_d, b_fire, c_load;

    logic [PIX_W-1:0] up_pixel, mid_pixel;
    logic [SUM_W-1:0] sum_c;
    logic [PIX_W-1:0] center_c;
    bb3s_ctl_t        ctl_c;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= CFG_WIDTH_W'(1192);
            height_reg <= CFG_HEIGHT_W'(500);
        end else if (cfg_wen) begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_wdata[CFG_WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT: height_reg <= cfg_wdata[CFG_HEIGHT_W-1:0];
                default:          ;
            endcase
        end
    end

    // clamped geometry
    always_comb begin
        w_ext = 32'(width_reg);
        if (w_ext < 32'd3)
            w_ext = 32'd3;
        else if (w_ext > 32'(MAX_WIDTH))
            w_ext = 32'(MAX_WIDTH);
        h_ext = 32'(height_reg);
        if (h_ext < 32'd3)
            h_ext = 32'd3;
        else if (h_ext > 32'(MAX_HEIGHT))
            h_ext = 32'(MAX_HEIGHT);
    end

    // pipeline flow: a stage moves when the next one has room
    assign en_d    = !valid_d_reg || m_ready;
    assign en_c    = !valid_c_reg || en_d;
    assign b_fire  = valid_b_reg && (!emit_b_reg || en_c);
    assign c_load  = b_fire && emit_b_reg;
    assign en_b    = !valid_b_reg || b_fire;
    assign s_ready = en_b;
    assign accept  = s_valid && s_ready;

    // position decode for the incoming transfer
    always_comb begin
        col_ext      = 32'(col_reg);
        row_ext      = 32'(row_reg);
        ignore       = (s_data.op == OP_FLUSH) && (row_ext < h_ext);
        proc         = accept && !ignore;
        pixel_a      = (row_ext >= h_ext) ? '0 : s_data.pixel_in;
        emit_a       = (row_ext >= 32'd2) || (row_ext == 32'd1 && col_ext >= 32'd1);
        ctl_a.border = (col_ext <= 32'd1) || (row_ext == 32'd1) || (row_ext >= h_ext)
                     || (col_ext >= w_ext);
        ctl_a.last   = row_ext > h_ext;

        col_inc  = col_ext + 32'd1;
        col_next = col_inc[IW-1:0];
        row_next = row_reg;
        if (col_inc >= w_ext) begin
            col_next = '0;
            row_next = row_reg + RW'(1);
        end
        if (emit_a && ctl_a.last) begin
            col_next = '0;
            row_next = '0;
        end
    end

    // position counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (proc) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // stage b: waits on the line memory read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_b_reg <= 1'b0;
        end else if (en_b) begin
            valid_b_reg <= proc;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc) begin
            emit_b_reg  <= emit_a;
            pixel_b_reg <= pixel_a;
            addr_b_reg  <= col_reg;
            ctl_b_reg   <= ctl_a;
        end
    end

    // stage c and output stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_c_reg <= 1'b0;
            valid_d_reg <= 1'b0;
        end else begin
            if (en_c)
                valid_c_reg <= c_load;
            if (en_d)
                valid_d_reg <= valid_c_reg;
        end
    end

    bb3s_line_buf #(
        .MAX_WIDTH (MAX_WIDTH),
        .ADDR_W    (IW)
    ) u_line_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (proc),
        .rd_addr   (col_reg),
        .wr_en     (b_fire),
        .wr_addr   (addr_b_reg),
        .wr_pixel  (pixel_b_reg),
        .up_pixel  (up_pixel),
        .mid_pixel (mid_pixel)
    );

    bb3s_window u_window (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .shift_en   (b_fire),
        .load_en    (c_load),
        .up_pixel   (up_pixel),
        .mid_pixel  (mid_pixel),
        .new_pixel  (pixel_b_reg),
        .ctl_in     (ctl_b_reg),
        .sum_reg    (sum_c),
        .center_reg (center_c),
        .ctl_reg    (ctl_c)
    );

    bb3s_div9 u_div9 (
        .aclk    (aclk),
        .load_en (valid_c_reg && en_d),
        .sum     (sum_c),
        .center  (center_c),
        .ctl     (ctl_c),
        .out_reg (m_data)
    );

    assign m_valid = valid_d_reg;

`ifndef NO_ASSERTIONS
    // the frame-ending item returns the position to the frame start
    a_last_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        proc && emit_a && ctl_a.last |=> col_reg == '0 && row_reg == '0)
        else $error("frame end did not restart position");

    // an early flush leaves the position untouched
    a_flush_ignored: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && ignore |=> $stable(col_reg) && $stable(row_reg))
        else $error("ignored flush moved position");

    // row counter never runs past the drain row
    a_row_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(row_reg) <= 32'(MAX_HEIGHT + 1))
        else $error("row counter out of range");

    // a result only reaches the output stage from a loaded sum stage
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !valid_d_reg && !valid_c_reg |=> !valid_d_reg)
        else $error("output valid without source");
`endif

endmodule

`default_nettype wire

// ----- rtl/bb3s_line_buf.sv -----
// two line memories (upper and middle row) with registered read
// read-modify-write: column entry is read at accept, written back one stage later
// depends on bb3s_pkg
`default_nettype none

module bb3s_line_buf
    import bb3s_pkg::*;
#(
    parameter int MAX_WIDTH = 2048,
    parameter int ADDR_W    = 11
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [PIX_W-1:0]  wr_pixel,
    output logic      [PIX_W-1:0]  up_pixel,
    output logic      [PIX_W-1:0]  mid_pixel
);

    logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
    logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

    logic [PIX_W-1:0] up_rd_reg;
    logic [PIX_W-1:0] mid_rd_reg;
    logic             fwd_reg;
    logic [PIX_W-1:0] fwd_up_reg;
    logic [PIX_W-1:0] fwd_mid_reg;

    // write back: middle row moves up, new pixel becomes middle row
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            upper_mem[wr_addr]  <= mid_pixel;
            middle_mem[wr_addr] <= wr_pixel;
        end
    end

    // registered read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            up_rd_reg  <= upper_mem[rd_addr];
            mid_rd_reg <= middle_mem[rd_addr];
        end
    end

    // bypass when the read hits the entry written back in the same cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg <= 1'b0;
        end else if (rd_en) begin
            fwd_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            fwd_up_reg  <= mid_pixel;
            fwd_mid_reg <= wr_pixel;
        end
    end

    assign up_pixel  = fwd_reg ? fwd_up_reg  : up_rd_reg;
    assign mid_pixel = fwd_reg ? fwd_mid_reg : mid_rd_reg;

endmodule

`default_nettype wire

// ----- rtl/bb3s_window.sv -----
// 3x3 sliding window registers and the registered neighborhood sum
// depends on bb3s_pkg
`default_nettype none

module bb3s_window
    import bb3s_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             shift_en,
    input  wire logic             load_en,
    input  wire logic [PIX_W-1:0] up_pixel,
    input  wire logic [PIX_W-1:0] mid_pixel,
    input  wire logic [PIX_W-1:0] new_pixel,
    input  wire bb3s_ctl_t        ctl_in,
    output logic      [SUM_W-1:0] sum_reg,
    output logic      [PIX_W-1:0] center_reg,
    output bb3s_ctl_t             ctl_reg
);

    logic [PIX_W-1:0] win_reg [9];
    logic [SUM_W-1:0] sum_next;

    // sum over the window as it stands after this shift
    always_comb begin
        sum_next = SUM_W'(win_reg[1]) + SUM_W'(win_reg[2]) + SUM_W'(up_pixel)
                 + SUM_W'(win_reg[4]) + SUM_W'(win_reg[5]) + SUM_W'(mid_pixel)
                 + SUM_W'(win_reg[7]) + SUM_W'(win_reg[8]) + SUM_W'(new_pixel);
    end

    // shift one column left, new column enters on the right
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 9; i++) begin
                win_reg[i] <= '0;
            end
        end else if (shift_en) begin
            for (int r = 0; r < 3; r++) begin
                win_reg[r*3]     <= win_reg[r*3 + 1];
                win_reg[r*3 + 1] <= win_reg[r*3 + 2];
            end
            win_reg[2] <= up_pixel;
            win_reg[5] <= mid_pixel;
            win_reg[8] <= new_pixel;
        end
    end

    // sum stage
    always_ff @(posedge aclk) begin
        if (load_en) begin
            sum_reg    <= sum_next;
            center_reg <= win_reg[5];
            ctl_reg    <= ctl_in;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/bb3s_div9.sv -----
// divide-by-9 via reciprocal multiply, border select and output register
// depends on bb3s_pkg
`default_nettype none

module bb3s_div9
    import bb3s_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             load_en,
    input  wire logic [SUM_W-1:0] sum,
    input  wire logic [PIX_W-1:0] center,
    input  wire bb3s_ctl_t        ctl,
    output bb3s_out_t             out_reg
);

    logic [PROD_W-1:0] prod;
    logic [PIX_W-1:0]  quot;
    bb3s_out_t         out_next;

    // truncated mean, border pixels pass through
    always_comb begin
        prod                = PROD_W'(sum) * PROD_W'(RECIP_9);
        quot                = prod[RECIP_SHIFT +: PIX_W];
        out_next.pixel_out  = ctl.border ? center : quot;
        out_next.frame_last = ctl.last;
    end

    always_ff @(posedge aclk) begin
        if (load_en) begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

// ----- verif/box_blur_3x3_stream_checker.sv -----
`timescale 1ns / 100ps
// checker for the 3x3 box blur stream: follows register writes and input transfers,
// predicts every result with its own line stores and window, compares results in order
// depends on bb3s_pkg
module box_blur_3x3_stream_checker
    import bb3s_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_wen,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                   s_valid,
    input  wire logic                   s_ready,
    input  wire bb3s_in_t               s_data,
    input  wire logic                   m_valid,
    input  wire logic                   m_ready,
    input  wire bb3s_out_t              m_data,
    output int                          fail_count,
    output int                          pending_results,
    output int                          results_checked
);

    localparam int REPORT_LIMIT = 10;

    // predicted block state
    logic [PIX_W-1:0]        upper_row  [MAX_WIDTH];
    logic [PIX_W-1:0]        middle_row [MAX_WIDTH];
    logic [PIX_W-1:0]        taps [9];
    int unsigned             col_pos;
    int unsigned             row_pos;
    logic [22:0]             emitted;
    logic [CFG_WIDTH_W-1:0]  width_reg;
    logic [CFG_HEIGHT_W-1:0] height_reg;

    bb3s_out_t expected_pixels [$];
    bb3s_out_t want;
    int        failures;
    int        checked;
    int        i;

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
        if (v < 3) begin
            return 3;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    // one input transfer: shift the window, update the line stores, queue the result it causes
    task automatic slide_window(input bb3s_in_t item);
        int unsigned      w;
        int unsigned      h;
        int unsigned      idx;
        int unsigned      orow;
        int unsigned      ocol;
        int unsigned      sum;
        int               r;
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] up;
        logic [PIX_W-1:0] mid;
        bit               emit;
        bit               last;
        bb3s_out_t        res;
        w = clamp_dim(32'(width_reg), MAX_WIDTH);
        h = clamp_dim(32'(height_reg), MAX_HEIGHT);
        px = item.pixel_in;
        // a flush before the frame is complete changes nothing
        if (!(item.op == OP_FLUSH && row_pos < h)) begin
            // past the last row every item is a drain tick storing zero
            if (row_pos >= h) begin
                px = '0;
            end
            idx = (col_pos < MAX_WIDTH) ? col_pos : 0;
            up = upper_row[idx];
            mid = middle_row[idx];
            for (r = 0; r < 3; r++) begin
                taps[r*3]   = taps[r*3+1];
                taps[r*3+1] = taps[r*3+2];
            end
            taps[2] = up;
            taps[5] = mid;
            taps[8] = px;
            upper_row[idx] = mid;
            middle_row[idx] = px;

            // the result belongs to the pixel one row and one column back
            emit = (row_pos >= 2) || (row_pos == 1 && col_pos >= 1);
            if (col_pos >= 1) begin
                orow = row_pos - 1;
                ocol = col_pos - 1;
            end else begin
                orow = (row_pos >= 2) ? row_pos - 2 : 0;
                ocol = w - 1;
            end
            last = (row_pos >= h + 1);

            col_pos++;
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos++;
            end

            if (emit) begin
                if (orow == 0 || orow >= h - 1 || ocol == 0 || ocol >= w - 1) begin
                    res.pixel_out = taps[4];
                end else begin
                    sum = 0;
                    for (r = 0; r < 9; r++) begin
                        sum += taps[r];
                    end
                    res.pixel_out = PIX_W'(sum / 9);
                end
                res.frame_last = last;
                expected_pixels.push_back(res);
                emitted = emitted + 1'b1;
                if (last) begin
                    col_pos = 0;
                    row_pos = 0;
                    emitted = '0;
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (i = 0; i < MAX_WIDTH; i++) begin
                upper_row[i] = '0;
                middle_row[i] = '0;
            end
            for (i = 0; i < 9; i++) begin
                taps[i] = '0;
            end
            col_pos = 0;
            row_pos = 0;
            emitted = '0;
            width_reg = CFG_WIDTH_W'(1192);
            height_reg = CFG_HEIGHT_W'(500);
            expected_pixels.delete();
        end else begin
            // register writes
            if (cfg_wen) begin
                if (cfg_index == CFG_IMAGE_WIDTH) begin
                    width_reg = cfg_wdata[CFG_WIDTH_W-1:0];
                end else if (cfg_index == CFG_IMAGE_HEIGHT) begin
                    height_reg = cfg_wdata[CFG_HEIGHT_W-1:0];
                end
            end
            // input transfer
            if (s_valid && s_ready) begin
                slide_window(s_data);
            end
            // result transfer against the oldest prediction
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    failures++;
                    if (failures <= REPORT_LIMIT) begin
                        $display("%0t: result with none predicted: pixel_out=%0d frame_last=%0b",
                                 $time, m_data.pixel_out, m_data.frame_last);
                    end
                end else begin
                    want = expected_pixels.pop_front();
                    checked++;
                    if (m_data.pixel_out !== want.pixel_out ||
                        m_data.frame_last !== want.frame_last) begin
                        failures++;
                        if (failures <= REPORT_LIMIT) begin
                            $display({"%0t: result %0d mismatch: pixel_out exp %0d got %0d,",
                                      " frame_last exp %0b got %0b"},
                                     $time, checked, want.pixel_out, m_data.pixel_out,
                                     want.frame_last, m_data.frame_last);
                        end
                    end
                end
            end
        end
        fail_count <= failures;
        pending_results <= expected_pixels.size();
        results_checked <= checked;
    end

endmodule

// ----- verif/box_blur_3x3_stream_tb.sv -----
`timescale 1ns / 100ps
// testbench top for box_blur_3x3_stream: clock, reset, register writes, paced frames
// of pixels with drain ticks and noise, and the verdict
// depends on bb3s_pkg, box_blur_3x3_stream and box_blur_3x3_stream_checker
module box_blur_3x3_stream_tb;
    import bb3s_pkg::*;

    localparam int MAX_WIDTH     = 2048;
    localparam int MAX_HEIGHT    = 4096;
    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 6;
    // settling margin after the drain before touching the registers
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 1000;
    localparam int RANDOM_ITEMS  = 740;
    localparam int MAX_GAP       = 18;

    typedef enum {PACE_STEADY, PACE_BURSTY, PACE_SPARSE} pace_e;
    typedef enum {PIX_NOISE, PIX_EXTREME, PIX_BRIGHT, PIX_RAMP} pix_style_e;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wen;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_valid;
    logic                   s_ready;
    bb3s_in_t               s_data;
    logic                   m_valid;
    logic                   m_ready;
    bb3s_out_t              m_data;

    int    fail_count;
    int    pending_results;
    int    results_checked;
    pace_e src_pace;
    pace_e sink_pace;
    int    items_sent;
    int    frames_run;
    int    quiet_cycles;

    box_blur_3x3_stream #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    box_blur_3x3_stream_checker #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wen         (cfg_wen),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .fail_count      (fail_count),
        .pending_results (pending_results),
        .results_checked (results_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #HALF_PERIOD aclk = ~aclk;
    end

    // idle cycles ahead of one transfer
    function automatic int draw_gap(input pace_e pace);
        case (pace)
            PACE_STEADY: begin
                return 0;
            end
            PACE_BURSTY: begin
                return ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_GAP) : 0;
            end
            default: begin
                return $urandom_range(0, MAX_GAP);
            end
        endcase
    endfunction

    function automatic int used_dim(input int raw, input int hi);
        if (raw < 3) begin
            return 3;
        end
        if (raw > hi) begin
            return hi;
        end
        return raw;
    endfunction

    // one input transfer, payload held until accepted
    task automatic send_item(input logic op, input logic [PIX_W-1:0] px);
        int gap;
        gap = draw_gap(src_pace);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data.op = op;
        s_data.pixel_in = px;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // hold the sender until every predicted result has come out
    task automatic wait_drained();
        s_valid = 1'b0;
        while (pending_results != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_wen = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_wen = 1'b0;
    endtask

    // one whole frame: configure, pixels with optional early flushes, then the drain ticks
    task automatic run_frame(input int w_raw, input int h_raw, input pix_style_e style,
                             input pace_e tx_pace, input pace_e rx_pace, input int noise_pct);
        int                    w;
        int                    h;
        int                    n;
        int                    k;
        logic [PIX_W-1:0]      px;
        logic [CFG_DATA_W-1:0] wv;
        w = used_dim(w_raw, MAX_WIDTH);
        h = used_dim(h_raw, MAX_HEIGHT);
        // registers change only with the pipeline empty
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        wv = CFG_DATA_W'(w_raw);
        // the bit above the width field is dropped by the block
        wv[CFG_DATA_W-1] = 1'($urandom_range(0, 1));
        write_reg(CFG_IMAGE_WIDTH, wv);
        write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h_raw));
        src_pace = tx_pace;
        sink_pace = rx_pace;

        for (n = 0; n < w * h; n++) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                send_item(OP_FLUSH, PIX_W'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 299) == 0) begin
                wait_drained();
            end
            case (style)
                PIX_EXTREME: begin
                    px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                end
                PIX_BRIGHT: begin
                    px = 8'hFF;
                end
                PIX_RAMP: begin
                    px = PIX_W'(n * 37);
                end
                default: begin
                    px = PIX_W'($urandom_range(0, 255));
                end
            endcase
            send_item(OP_PIXEL, px);
        end
        // drain: width + 1 ticks, some sent as pixels whose values are dropped
        for (k = 0; k <= w; k++) begin
            send_item(($urandom_range(0, 2) == 0) ? OP_PIXEL : OP_FLUSH,
                      PIX_W'($urandom_range(0, 255)));
        end
        frames_run++;
        items_sent += w * h + w + 1;
    endtask

    // result side: per result a drawn stall, then ready until the transfer
    initial begin : result_sink
        int stall;
        m_ready = 1'b0;
        forever begin
            stall = draw_gap(sink_pace);
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            @(negedge aclk);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, pending_results);
            $display("[box_blur_3x3_stream] ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        int start_count;
        int w;
        int h;
        aresetn = 1'b0;
        cfg_wen = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_data = '0;
        src_pace = PACE_STEADY;
        sink_pace = PACE_STEADY;
        items_sent = 0;
        frames_run = 0;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed: smallest frame from clamped low values, full-scale pixels, early flushes
        run_frame(1, 0, PIX_BRIGHT, PACE_STEADY, PACE_STEADY, 30);
        // directed: ramp through zero and varied values, slow on both sides
        run_frame(3, 3, PIX_RAMP, PACE_SPARSE, PACE_SPARSE, 0);

        // wide frame with a clamped height, then a tall frame with a clamped width
        run_frame(100, 2, PIX_NOISE, PACE_STEADY, PACE_STEADY, 0);
        run_frame(2, 60, PIX_EXTREME, PACE_STEADY, PACE_BURSTY, 1);

        // random frames, mostly small
        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS) begin
            if ($urandom_range(0, 5) == 0) begin
                w = $urandom_range(3, 40);
                h = 3;
            end else begin
                w = $urandom_range(0, 10);
                h = $urandom_range(0, 7);
            end
            run_frame(w, h, pix_style_e'($urandom_range(0, 3)), pace_e'($urandom_range(0, 2)),
                      pace_e'($urandom_range(0, 2)), $urandom_range(0, 1) ? 0 : 8);
        end

        // let the last frame come out
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);

        $display("covered %0d frames, %0d counted input transfers, %0d results compared",
                 frames_run, items_sent, results_checked);
        $display("sizes from 3 up to 100 wide and 60 high, early flushes, pixels while draining");
        if (fail_count == 0 && pending_results == 0) begin
            $display("[box_blur_3x3_stream] OK");
        end else begin
            $display("[box_blur_3x3_stream] ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/bb3s_pkg.sv
rtl/bb3s_line_buf.sv
rtl/bb3s_window.sv
rtl/bb3s_div9.sv
rtl/box_blur_3x3_stream.sv
verif/box_blur_3x3_stream_checker.sv
verif/box_blur_3x3_stream_tb.sv
